>>> hdl/accb_pkg.sv
package accb_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 22;
    localparam int CH_W      = 4;
    localparam int ACT_W     = 5;
    localparam int MASK_W    = 16;
    localparam int FRM_W     = 7;
    localparam int FIDX_W    = 6;
    localparam int VMIN_W    = 16;
    localparam int LIMIT_W   = FRM_W + VMIN_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int DEF_N_POS = 16;
    localparam logic [FRM_W-1:0] MAX_FRAMES = FRM_W'(64);
    localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MASK     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_WD_EN    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_WD_CHAN  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_WD_VMIN  = CFG_IDX_W'(5);

    // register reset values
    localparam logic [ACT_W-1:0]  RST_ACTIVE  = ACT_W'(16);
    localparam logic [MASK_W-1:0] RST_MASK    = '0;
    localparam logic [FRM_W-1:0]  RST_FRAMES  = FRM_W'(8);
    localparam logic [CH_W-1:0]   RST_WD_CHAN = '0;
    localparam logic [VMIN_W-1:0] RST_WD_VMIN = VMIN_W'(4095);

    typedef enum logic {
        ST_ACC,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic acc;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> hdl/adc_channel_block_accumulator.sv
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_valid / s_ready  | s_sample
// m_        | out       | m_valid / m_ready  | m_channel, m_sum, m_sample_count,
//           |           |                    | m_low_alarm, m_last
// cfg_      | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One sample per cycle is taken while a block accumulates.
// After the last sample of a block the cell row shifts toward cell 0, pausing
// while a reporting head waits for the output register; zeros enter at the
// far end, so the row is clear after the drain. s_ready is low meanwhile.
// Reset clears all sums, the rotation position and the frame index.
module adc_channel_block_accumulator
    import accb_pkg::*;
#(
    parameter int N_POS = DEF_N_POS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CH_W-1:0]      m_channel,
    output logic [SUM_W-1:0]     m_sum,
    output logic [FRM_W-1:0]     m_sample_count,
    output logic                 m_low_alarm,
    output logic                 m_last
);

    localparam logic [CH_W-1:0] CNT_LAST = CH_W'(N_POS - 1);

    logic [ACT_W-1:0]   active_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [FRM_W-1:0]   frames_reg;
    logic               wd_en_reg;
    logic [CH_W-1:0]    wd_chan_reg;
    logic [VMIN_W-1:0]  vmin_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic [ACT_W-1:0]   act_eff;
    logic [FRM_W-1:0]   frm_eff;
    logic [MASK_W-1:0]  rep_mask;
    logic               later_any;

    state_t             state_reg;
    state_t             state_next;
    logic [CH_W-1:0]    pos_reg;
    logic [FIDX_W-1:0]  frame_reg;
    logic [CH_W-1:0]    cnt_reg;

    logic               accept;
    logic               pos_last;
    logic               frame_last;
    logic               drain;
    logic               out_free;
    logic               advance;
    logic               load;

    logic               m_valid_reg;
    logic [CH_W-1:0]    m_channel_reg;
    logic [SUM_W-1:0]   m_sum_reg;
    logic [FRM_W-1:0]   m_count_reg;
    logic               m_alarm_reg;
    logic               m_last_reg;

    logic [SUM_W-1:0]   sums [N_POS];
    cell_ctrl_t         ctrl [N_POS];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= RST_ACTIVE;
            mask_reg    <= RST_MASK;
            frames_reg  <= RST_FRAMES;
            wd_en_reg   <= 1'b0;
            wd_chan_reg <= RST_WD_CHAN;
            vmin_reg    <= RST_WD_VMIN;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ACTIVE:  active_reg  <= cfg_wr_data[ACT_W-1:0];
                REG_MASK:    mask_reg    <= cfg_wr_data[MASK_W-1:0];
                REG_FRAMES:  frames_reg  <= cfg_wr_data[FRM_W-1:0];
                REG_WD_EN:   wd_en_reg   <= cfg_wr_data[0];
                REG_WD_CHAN: wd_chan_reg <= cfg_wr_data[CH_W-1:0];
                REG_WD_VMIN: vmin_reg    <= cfg_wr_data[VMIN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp counts into their legal ranges
    always_comb begin
        act_eff = active_reg;
        if (active_reg == '0) begin
            act_eff = ACT_W'(1);
        end else if (active_reg > ACT_W'(N_POS)) begin
            act_eff = ACT_W'(N_POS);
        end
        frm_eff = frames_reg;
        if (frames_reg == '0) begin
            frm_eff = FRM_W'(1);
        end else if (frames_reg > MAX_FRAMES) begin
            frm_eff = MAX_FRAMES;
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg <= LIMIT_W'(frm_eff) * LIMIT_W'(vmin_reg);
    end

    // positions that report, and whether any report after the head
    always_comb begin
        rep_mask  = '0;
        later_any = 1'b0;
        for (int p = 0; p < MASK_W; p++) begin
            rep_mask[p] = mask_reg[p] && (p < N_POS) && (ACT_W'(p) < act_eff);
        end
        for (int p = 0; p < MASK_W; p++) begin
            if (rep_mask[p] && (CH_W'(p) > cnt_reg)) begin
                later_any = 1'b1;
            end
        end
    end

    assign accept     = s_valid && s_ready;
    assign pos_last   = (ACT_W'(pos_reg) + ACT_W'(1)) >= act_eff;
    assign frame_last = (FRM_W'(frame_reg) + FRM_W'(1)) >= frm_eff;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC: begin
                if (accept && pos_last && frame_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (advance && (cnt_reg == CNT_LAST)) begin
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        drain    = 1'b0;
        case (state_reg)
            ST_ACC:   s_ready = 1'b1;
            ST_DRAIN: drain   = 1'b1;
            default: ;
        endcase
        out_free = !m_valid_reg || m_ready;
        // hold the row while a reporting head waits for the output register
        advance  = drain && (!rep_mask[cnt_reg] || out_free);
        load     = drain && rep_mask[cnt_reg] && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            pos_reg   <= '0;
            frame_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                pos_reg <= pos_last ? '0 : pos_reg + CH_W'(1);
                if (pos_last) begin
                    frame_reg <= frame_last ? '0 : frame_reg + FIDX_W'(1);
                end
            end
            if (advance) begin
                cnt_reg <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + CH_W'(1);
            end
        end
    end

    // cell row: cell 0 is the head, data moves toward it during the drain
    for (genvar i = 0; i < N_POS; i++) begin : g_cell
        logic [SUM_W-1:0] shift_in;

        if (i == N_POS - 1) begin : g_tail
            assign shift_in = '0;
        end else begin : g_mid
            assign shift_in = sums[i+1];
        end

        assign ctrl[i].acc   = accept && (pos_reg == CH_W'(i));
        assign ctrl[i].shift = advance;

        accb_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl[i]),
            .sample   (s_sample),
            .shift_in (shift_in),
            .sum      (sums[i])
        );
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_channel_reg <= cnt_reg;
            m_sum_reg     <= sums[0];
            m_count_reg   <= frm_eff;
            m_alarm_reg   <= wd_en_reg && (wd_chan_reg == cnt_reg) &&
                             (LIMIT_W'(sums[0]) < limit_reg);
            m_last_reg    <= !later_any;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_channel      = m_channel_reg;
    assign m_sum          = m_sum_reg;
    assign m_sample_count = m_count_reg;
    assign m_low_alarm    = m_alarm_reg;
    assign m_last         = m_last_reg;

endmodule

>>> hdl/accb_cell.sv
module accb_cell
    import accb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SUM_W-1:0]    shift_in,
    output logic [SUM_W-1:0]    sum
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W:0]   add;

    always_comb begin
        add = {1'b0, sum_reg} + (SUM_W+1)'(sample);
        sum_next = sum_reg;
        if (ctrl.shift) begin
            sum_next = shift_in;
        end else if (ctrl.acc) begin
            // saturate at full scale
            sum_next = add[SUM_W] ? SUM_MAX : add[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

>>> hdl/accb_checker.sv
module accb_checker
    import accb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [CH_W-1:0]     m_channel,
    input  logic [SUM_W-1:0]    m_sum,
    input  logic [FRM_W-1:0]    m_sample_count,
    input  logic                m_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum) && $stable(m_channel))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample_count != '0) && (m_sample_count <= MAX_FRAMES))
        else $error("sample count out of range");

    // a sample is taken only once the block's final result has been loaded
    a_no_input_mid_block: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_valid |-> m_last)
        else $error("input taken in the middle of a result block");

    a_ascending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !m_valid || (m_channel > $past(m_channel)))
        else $error("channels out of order within a block");

endmodule

bind adc_channel_block_accumulator accb_checker u_accb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_channel      (m_channel),
    .m_sum          (m_sum),
    .m_sample_count (m_sample_count),
    .m_last         (m_last)
);
